@@ rtl/cds_pkg.sv @@
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, command codes and calendar helper functions for the
// Gregorian date stepper.
// ----------------------------------------------------------------------------
package cds_pkg;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} date_t;

	localparam logic [2:0] FUNC_LOAD       = 3'd0;
	localparam logic [2:0] FUNC_PREV_DAY   = 3'd1;
	localparam logic [2:0] FUNC_NEXT_DAY   = 3'd2;
	localparam logic [2:0] FUNC_PREV_MONTH = 3'd3;
	localparam logic [2:0] FUNC_NEXT_MONTH = 3'd4;

	localparam logic [13:0] RESET_YEAR  = 14'd2000;
	localparam logic [3:0]  RESET_MONTH = 4'd1;
	localparam logic [4:0]  RESET_DAY   = 5'd1;

	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_MAR = 4'd3;
	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_JUN = 4'd6;
	localparam logic [3:0] MONTH_SEP = 4'd9;
	localparam logic [3:0] MONTH_NOV = 4'd11;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	// floor(y / 100) by reciprocal, exact for every 14-bit year
	function automatic logic [7:0] cds_div100(input logic [13:0] y);
		logic [26:0] p;
		begin
			p = 27'(y) * 27'd5243;
			return p[26:19];
		end
	endfunction

	// leap rule, q is floor(y / 100)
	function automatic logic cds_leap(input logic [13:0] y, input logic [7:0] q);
		logic [13:0] r;
		begin
			r = y - (14'(q) * 14'd100);
			return (y[1:0] == 2'd0) && ((r != 14'd0) || (q[1:0] == 2'd0));
		end
	endfunction

	function automatic logic [4:0] cds_mlen(input logic leap, input logic [3:0] m);
		begin
			case (m)
				MONTH_FEB: return leap ? 5'd29 : 5'd28;
				MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 5'd30;
				default: return 5'd31;
			endcase
		end
	endfunction

	// floor(23 * m / 9)
	function automatic logic [4:0] cds_moff(input logic [3:0] m);
		begin
			case (m)
				4'd1: return 5'd2;
				4'd2: return 5'd5;
				4'd3: return 5'd7;
				4'd4: return 5'd10;
				4'd5: return 5'd12;
				4'd6: return 5'd15;
				4'd7: return 5'd17;
				4'd8: return 5'd20;
				4'd9: return 5'd23;
				4'd10: return 5'd25;
				4'd11: return 5'd28;
				default: return 5'd30;
			endcase
		end
	endfunction

	// weekday of the first of month m, 0 is sunday
	function automatic logic [2:0] cds_weekday(input logic [13:0] y, input logic [3:0] m,
			input logic [7:0] q, input logic leap);
		logic [14:0] s;
		logic [5:0]  f1;
		logic [3:0]  f2;
		logic [2:0]  w;
		begin
			s = 15'(cds_moff(m)) + 15'd5 + 15'(y) + 15'(y[13:2]) - 15'(q) + 15'(q[7:2]);
			if (m >= MONTH_MAR) begin
				s = s - 15'd2;
			end
			// 8 is 1 mod 7: fold octal digits
			f1 = 6'(s[2:0]) + 6'(s[5:3]) + 6'(s[8:6]) + 6'(s[11:9]) + 6'(s[14:12]);
			f2 = 4'(f1[2:0]) + 4'(f1[5:3]);
			w  = (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
			if ((m < MONTH_MAR) && leap) begin
				w = (w == 3'd0) ? 3'd6 : w - 3'd1;
			end
			return w;
		end
	endfunction

endpackage

@@ rtl/cds_step.sv @@
// ----------------------------------------------------------------------------
// cds_step
// Date state register and next-date logic: applies one command per cycle
// while ready_s2 is high; holds the result date and error for the info stage.
// ----------------------------------------------------------------------------
module cds_step #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s1,
	input  logic [2:0]     func_s1,
	input  logic [13:0]    load_year_s1,
	input  logic [3:0]     load_month_s1,
	input  logic [4:0]     load_day_s1,
	input  logic           ready_s3,
	output logic           ready_s2,
	output logic           valid_s2,
	output cds_pkg::date_t date_q,
	output logic           err_s2
);
	import cds_pkg::*;

	localparam logic [13:0] YEAR_LIMIT = 14'(MAX_YEAR);

	logic       adv_s1;
	logic       leap_cur;
	logic       leap_ld;
	logic [4:0] len_cur;
	logic [4:0] len_dn;
	logic [4:0] len_up;
	logic       load_ok;
	date_t      nxt;
	logic       err;

	assign ready_s2 = !valid_s2 || ready_s3;
	assign adv_s1   = valid_s1 && ready_s2;

	assign leap_cur = cds_leap(date_q.year, cds_div100(date_q.year));
	assign leap_ld  = cds_leap(load_year_s1, cds_div100(load_year_s1));
	assign len_cur  = cds_mlen(leap_cur, date_q.month);
	assign len_dn   = cds_mlen(leap_cur, date_q.month - 4'd1);
	assign len_up   = cds_mlen(leap_cur, date_q.month + 4'd1);

	assign load_ok = (load_year_s1 <= YEAR_LIMIT) && (load_month_s1 >= 4'd1) &&
		(load_month_s1 <= MONTH_DEC) && (load_day_s1 >= 5'd1) &&
		(load_day_s1 <= cds_mlen(leap_ld, load_month_s1));

	always_comb begin
		nxt = date_q;
		err = 1'b0;
		case (func_s1)
			FUNC_LOAD: begin
				if (load_ok) begin
					nxt.year  = load_year_s1;
					nxt.month = load_month_s1;
					nxt.day   = load_day_s1;
				end else begin
					err = 1'b1;
				end
			end
			FUNC_PREV_DAY: begin
				if (date_q.day > 5'd1) begin
					nxt.day = date_q.day - 5'd1;
				end else if (date_q.month > 4'd1) begin
					nxt.month = date_q.month - 4'd1;
					nxt.day   = len_dn;
				end else if (date_q.year > 14'd0) begin
					nxt.year  = date_q.year - 14'd1;
					nxt.month = MONTH_DEC;
					nxt.day   = 5'd31;
				end else begin
					err = 1'b1;
				end
			end
			FUNC_NEXT_DAY: begin
				if (date_q.day < len_cur) begin
					nxt.day = date_q.day + 5'd1;
				end else if (date_q.month < MONTH_DEC) begin
					nxt.month = date_q.month + 4'd1;
					nxt.day   = 5'd1;
				end else if (date_q.year < YEAR_LIMIT) begin
					nxt.year  = date_q.year + 14'd1;
					nxt.month = 4'd1;
					nxt.day   = 5'd1;
				end else begin
					err = 1'b1;
				end
			end
			FUNC_PREV_MONTH: begin
				if (date_q.month > 4'd1) begin
					nxt.month = date_q.month - 4'd1;
					if (date_q.day > len_dn) begin
						nxt.day = len_dn;
					end
				end else if (date_q.year > 14'd0) begin
					nxt.year  = date_q.year - 14'd1;
					nxt.month = MONTH_DEC;
				end else begin
					err = 1'b1;
				end
			end
			FUNC_NEXT_MONTH: begin
				if (date_q.month < MONTH_DEC) begin
					nxt.month = date_q.month + 4'd1;
					if (date_q.day > len_up) begin
						nxt.day = len_up;
					end
				end else if (date_q.year < YEAR_LIMIT) begin
					nxt.year  = date_q.year + 14'd1;
					nxt.month = 4'd1;
				end else begin
					err = 1'b1;
				end
			end
			default: begin
				nxt = date_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			date_q.year  <= RESET_YEAR;
			date_q.month <= RESET_MONTH;
			date_q.day   <= RESET_DAY;
			valid_s2     <= 1'b0;
			err_s2       <= 1'b0;
		end else begin
			if (adv_s1) begin
				date_q <= nxt;
				err_s2 <= err;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	a_date_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(date_q.month >= 4'd1) && (date_q.month <= MONTH_DEC) && (date_q.day >= 5'd1) &&
		(date_q.day <= len_cur) && (date_q.year <= YEAR_LIMIT))
		else $error("date register holds an invalid date");

	a_err_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && err) |=> $stable(date_q))
		else $error("refused request changed the date");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(date_q) && $stable(err_s2))
		else $error("date changed without a request");

endmodule

@@ rtl/cds_info.sv @@
// ----------------------------------------------------------------------------
// cds_info
// Result stage: derives month length and weekday of the first from the
// current date and holds the complete result for the receiver.
// ----------------------------------------------------------------------------
module cds_info (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s2,
	input  cds_pkg::date_t date_q,
	input  logic           err_s2,
	input  logic           res_stall,
	output logic           ready_s3,
	output logic           res_valid,
	output logic [13:0]    cur_year,
	output logic [3:0]     cur_month,
	output logic [4:0]     cur_day,
	output logic [4:0]     month_length,
	output logic [2:0]     first_weekday,
	output logic           error_flag
);
	import cds_pkg::*;

	logic       adv_s2;
	logic [7:0] cent;
	logic       leap;

	assign ready_s3 = !res_valid || !res_stall;
	assign adv_s2   = valid_s2 && ready_s3;
	assign cent     = cds_div100(date_q.year);
	assign leap     = cds_leap(date_q.year, cent);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (ready_s3) begin
			res_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			cur_year      <= date_q.year;
			cur_month     <= date_q.month;
			cur_day       <= date_q.day;
			month_length  <= cds_mlen(leap, date_q.month);
			first_weekday <= cds_weekday(date_q.year, date_q.month, cent, leap);
			error_flag    <= err_s2;
		end
	end

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (month_length >= 5'd28) && (cur_day <= month_length))
		else $error("result month length out of range");

	a_wday_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (first_weekday <= 3'd6))
		else $error("result weekday out of range");

endmodule

@@ rtl/calendar_date_stepper_core.sv @@
// ----------------------------------------------------------------------------
// calendar_date_stepper_core
// Gregorian date counter: load a date, or step one day or month either way.
//
// Request channel (cmd_valid / cmd_stall) carries func and the load fields;
// a request is taken at a clock edge with cmd_valid high and cmd_stall low.
// Result channel (res_valid / res_stall) returns exactly one result per
// request: the date after it, the length of its month, the weekday of the
// first of the month (0 is sunday) and error_flag for a refused request.
// Each request passes three registers on its way to a result: input
// register, date register, result register. A request is taken every cycle
// cmd_stall is low; the date update reads the date the previous request wrote.
// Reset (arst_n low) sets the date to 2000-01-01 and empties the pipeline.
// While res_stall is high the result holds; requests keep being taken until
// the three registers are full, then cmd_stall rises.
// ----------------------------------------------------------------------------
module calendar_date_stepper_core #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [2:0]  func,
	input  logic [13:0] load_year,
	input  logic [3:0]  load_month,
	input  logic [4:0]  load_day,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [13:0] cur_year,
	output logic [3:0]  cur_month,
	output logic [4:0]  cur_day,
	output logic [4:0]  month_length,
	output logic [2:0]  first_weekday,
	output logic        error_flag
);
	import cds_pkg::*;

	logic        valid_s1;
	logic        ready_s1;
	logic [2:0]  func_s1;
	logic [13:0] load_year_s1;
	logic [3:0]  load_month_s1;
	logic [4:0]  load_day_s1;
	logic        ready_s2;
	logic        ready_s3;
	logic        valid_s2;
	date_t       date_q;
	logic        err_s2;

	assign ready_s1  = !valid_s1 || ready_s2;
	assign cmd_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && cmd_valid) begin
			func_s1       <= func;
			load_year_s1  <= load_year;
			load_month_s1 <= load_month;
			load_day_s1   <= load_day;
		end
	end

	cds_step #(
		.MAX_YEAR(MAX_YEAR)
	) u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.func_s1      (func_s1),
		.load_year_s1 (load_year_s1),
		.load_month_s1(load_month_s1),
		.load_day_s1  (load_day_s1),
		.ready_s3     (ready_s3),
		.ready_s2     (ready_s2),
		.valid_s2     (valid_s2),
		.date_q       (date_q),
		.err_s2       (err_s2)
	);

	cds_info u_info (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s2     (valid_s2),
		.date_q       (date_q),
		.err_s2       (err_s2),
		.res_stall    (res_stall),
		.ready_s3     (ready_s3),
		.res_valid    (res_valid),
		.cur_year     (cur_year),
		.cur_month    (cur_month),
		.cur_day      (cur_day),
		.month_length (month_length),
		.first_weekday(first_weekday),
		.error_flag   (error_flag)
	);

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives calendar_date_stepper_core with a table of directed requests (field
// extremes, refused loads, steps past year zero and the year limit, unknown
// commands), then a long run of random loads and day/month steps. Each result
// is checked field by field against a date predictor or the row's fixed want.
// Both channels idle at random; one long result hold-off and one pause of the
// request side until all results are back are part of the run.
// ----------------------------------------------------------------------------
module testbench;
	import cds_pkg::*;

	localparam int unsigned MAX_YEAR = 9999;
	localparam int unsigned RANDOM_ITEMS = 1825;
	localparam int unsigned HOLD_ITEM = 520;
	localparam int unsigned HOLD_CYCLES = 64;
	localparam int unsigned PAUSE_ITEM = 1200;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned QUIET_LIMIT = 2000;

	localparam logic [2:0] FUNC_SPARE_A = 3'd5;
	localparam logic [2:0] FUNC_SPARE_B = 3'd6;
	localparam logic [2:0] FUNC_SPARE_C = 3'd7;

	typedef struct packed {
		logic [2:0]  func;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} request_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  mlen;
		logic [2:0]  wday;
		logic        err;
	} day_report_t;

	typedef struct packed {
		request_t    req;
		logic        typed;
		day_report_t want;
	} directed_row_t;

	localparam day_report_t NONE = '0;
	localparam int unsigned DIRECTED_ROWS = 26;
	localparam directed_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
		'{'{FUNC_SPARE_A,    14'd16383, 4'd15, 5'd31}, 1'b1,
			'{14'd2000, 4'd1, 5'd1, 5'd31, 3'd6, 1'b0}},
		'{'{FUNC_LOAD,       14'd16383, 4'd1,  5'd1},  1'b1,
			'{14'd2000, 4'd1, 5'd1, 5'd31, 3'd6, 1'b1}},
		'{'{FUNC_LOAD,       14'd2001,  4'd0,  5'd1},  1'b1,
			'{14'd2000, 4'd1, 5'd1, 5'd31, 3'd6, 1'b1}},
		'{'{FUNC_LOAD,       14'd2001,  4'd13, 5'd1},  1'b1,
			'{14'd2000, 4'd1, 5'd1, 5'd31, 3'd6, 1'b1}},
		'{'{FUNC_LOAD,       14'd2001,  4'd1,  5'd0},  1'b1,
			'{14'd2000, 4'd1, 5'd1, 5'd31, 3'd6, 1'b1}},
		'{'{FUNC_LOAD,       14'd2001,  4'd4,  5'd31}, 1'b1,
			'{14'd2000, 4'd1, 5'd1, 5'd31, 3'd6, 1'b1}},
		'{'{FUNC_LOAD,       14'd1900,  4'd2,  5'd29}, 1'b1,
			'{14'd2000, 4'd1, 5'd1, 5'd31, 3'd6, 1'b1}},
		'{'{FUNC_LOAD,       14'd0,     4'd1,  5'd1},  1'b1,
			'{14'd0, 4'd1, 5'd1, 5'd31, 3'd6, 1'b0}},
		'{'{FUNC_PREV_DAY,   14'd16383, 4'd15, 5'd31}, 1'b1,
			'{14'd0, 4'd1, 5'd1, 5'd31, 3'd6, 1'b1}},
		'{'{FUNC_PREV_MONTH, 14'd0,     4'd0,  5'd0},  1'b1,
			'{14'd0, 4'd1, 5'd1, 5'd31, 3'd6, 1'b1}},
		'{'{FUNC_NEXT_MONTH, 14'd0,     4'd0,  5'd0},  1'b0, NONE},
		'{'{FUNC_LOAD,       14'd2000,  4'd1,  5'd31}, 1'b0, NONE},
		'{'{FUNC_NEXT_MONTH, 14'd0,     4'd0,  5'd0},  1'b0, NONE},
		'{'{FUNC_LOAD,       14'(MAX_YEAR), 4'd12, 5'd31}, 1'b1,
			'{14'(MAX_YEAR), 4'd12, 5'd31, 5'd31, 3'd3, 1'b0}},
		'{'{FUNC_NEXT_DAY,   14'd0,     4'd0,  5'd0},  1'b1,
			'{14'(MAX_YEAR), 4'd12, 5'd31, 5'd31, 3'd3, 1'b1}},
		'{'{FUNC_NEXT_MONTH, 14'd0,     4'd0,  5'd0},  1'b1,
			'{14'(MAX_YEAR), 4'd12, 5'd31, 5'd31, 3'd3, 1'b1}},
		'{'{FUNC_PREV_MONTH, 14'd0,     4'd0,  5'd0},  1'b0, NONE},
		'{'{FUNC_LOAD,       14'd2100,  4'd3,  5'd1},  1'b0, NONE},
		'{'{FUNC_PREV_DAY,   14'd0,     4'd0,  5'd0},  1'b0, NONE},
		'{'{FUNC_LOAD,       14'd1999,  4'd12, 5'd31}, 1'b0, NONE},
		'{'{FUNC_NEXT_DAY,   14'd0,     4'd0,  5'd0},  1'b0, NONE},
		'{'{FUNC_LOAD,       14'd2004,  4'd3,  5'd31}, 1'b0, NONE},
		'{'{FUNC_PREV_MONTH, 14'd0,     4'd0,  5'd0},  1'b0, NONE},
		'{'{FUNC_SPARE_B,    14'd16383, 4'd15, 5'd31}, 1'b0, NONE},
		'{'{FUNC_LOAD,       14'd2001,  4'd1,  5'd1},  1'b0, NONE},
		'{'{FUNC_PREV_DAY,   14'd0,     4'd0,  5'd0},  1'b0, NONE}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic [2:0]  func = '0;
	logic [13:0] load_year = '0;
	logic [3:0]  load_month = '0;
	logic [4:0]  load_day = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [13:0] cur_year;
	logic [3:0]  cur_month;
	logic [4:0]  cur_day;
	logic [4:0]  month_length;
	logic [2:0]  first_weekday;
	logic        error_flag;

	date_t       date_state;
	day_report_t pending_reports[$];
	int unsigned errors = 0;
	int unsigned quiet_cycles = 0;

	calendar_date_stepper_core #(.MAX_YEAR(MAX_YEAR)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.func(func),
		.load_year(load_year),
		.load_month(load_month),
		.load_day(load_day),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.cur_year(cur_year),
		.cur_month(cur_month),
		.cur_day(cur_day),
		.month_length(month_length),
		.first_weekday(first_weekday),
		.error_flag(error_flag)
	);

	always #5 clk = ~clk;

	function automatic bit is_leap_year(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_days(int unsigned y, int unsigned m);
		case (m)
			MONTH_FEB: return is_leap_year(y) ? 29 : 28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic int unsigned weekday_of_first(int unsigned y, int unsigned m);
		int unsigned s;
		int unsigned w;
		s = (23 * m) / 9 + 5 + y + y / 4 - y / 100 + y / 400;
		if (m >= MONTH_MAR) begin
			s = s - 2;
		end
		w = s % 7;
		if (m < MONTH_MAR && is_leap_year(y)) begin
			w = (w == 0) ? 6 : w - 1;
		end
		return w;
	endfunction

	function automatic day_report_t step_date(request_t r);
		int unsigned y;
		int unsigned m;
		int unsigned d;
		bit          err;
		day_report_t rep;
		y = date_state.year;
		m = date_state.month;
		d = date_state.day;
		err = 1'b0;
		case (r.func)
			FUNC_LOAD: begin
				if (r.year > MAX_YEAR || r.month < 1 || r.month > 12 || r.day < 1 ||
						r.day > month_days(r.year, r.month)) begin
					err = 1'b1;
				end else begin
					y = r.year;
					m = r.month;
					d = r.day;
				end
			end
			FUNC_PREV_DAY: begin
				if (d > 1) begin
					d--;
				end else if (m > 1) begin
					m--;
					d = month_days(y, m);
				end else if (y > 0) begin
					y--;
					m = 12;
					d = 31;
				end else begin
					err = 1'b1;
				end
			end
			FUNC_NEXT_DAY: begin
				if (d < month_days(y, m)) begin
					d++;
				end else if (m < 12) begin
					m++;
					d = 1;
				end else if (y < MAX_YEAR) begin
					y++;
					m = 1;
					d = 1;
				end else begin
					err = 1'b1;
				end
			end
			FUNC_PREV_MONTH, FUNC_NEXT_MONTH: begin
				if (r.func == FUNC_PREV_MONTH) begin
					if (m > 1) begin
						m--;
					end else if (y > 0) begin
						y--;
						m = 12;
					end else begin
						err = 1'b1;
					end
				end else begin
					if (m < 12) begin
						m++;
					end else if (y < MAX_YEAR) begin
						y++;
						m = 1;
					end else begin
						err = 1'b1;
					end
				end
				if (!err && d > month_days(y, m)) begin
					d = month_days(y, m);
				end
			end
			default: begin
			end
		endcase
		date_state.year = 14'(y);
		date_state.month = 4'(m);
		date_state.day = 5'(d);
		rep.year = 14'(y);
		rep.month = 4'(m);
		rep.day = 5'(d);
		rep.mlen = 5'(month_days(y, m));
		rep.wday = 3'(weekday_of_first(y, m));
		rep.err = err;
		return rep;
	endfunction

	function automatic request_t random_request();
		request_t    r;
		int unsigned pick;
		int unsigned sel;
		pick = $urandom_range(0, 99);
		r.func = FUNC_LOAD;
		r.year = 14'($urandom_range(0, 16383));
		r.month = 4'($urandom_range(0, 15));
		r.day = 5'($urandom_range(0, 31));
		if (pick < 14) begin
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				r.year = 14'($urandom_range(0, 3));
			end else if (sel == 1) begin
				r.year = 14'(MAX_YEAR - $urandom_range(0, 3));
			end else if (sel == 2) begin
				r.year = 14'($urandom_range(0, MAX_YEAR / 100) * 100);
			end else begin
				r.year = 14'($urandom_range(0, MAX_YEAR));
			end
			r.month = 4'($urandom_range(1, 12));
			r.day = 5'($urandom_range(1, month_days(r.year, r.month)));
		end else if (pick < 18) begin
			if ($urandom_range(0, 1) == 0) begin
				r.year = '0;
				r.month = 4'd1;
				r.day = 5'($urandom_range(1, 2));
			end else begin
				r.year = 14'(MAX_YEAR);
				r.month = 4'd12;
				r.day = 5'($urandom_range(30, 31));
			end
		end else if (pick < 24) begin
			// malformed load, fields left as drawn
		end else if (pick < 27) begin
			r.func = 3'($urandom_range(FUNC_SPARE_A, FUNC_SPARE_C));
		end else begin
			r.func = 3'($urandom_range(FUNC_PREV_DAY, FUNC_NEXT_MONTH));
		end
		return r;
	endfunction

	function automatic int unsigned idle_draw(int unsigned n);
		if (n % 400 < 50) begin
			return 0;
		end
		return $urandom_range(0, 3);
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// request side
	initial begin
		request_t    req;
		day_report_t rep;
		int unsigned gap;
		bit          pause;
		date_state = '{year: RESET_YEAR, month: RESET_MONTH, day: RESET_DAY};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		for (int unsigned idx = 0; idx < DIRECTED_ROWS + RANDOM_ITEMS; idx++) begin
			req = (idx < DIRECTED_ROWS) ? DIRECTED[idx].req : random_request();
			pause = (idx == PAUSE_ITEM);
			gap = (idx >= HOLD_ITEM && idx < HOLD_ITEM + 100) ? 0 : idle_draw(idx);
			if (pause || gap != 0) begin
				cmd_valid <= 1'b0;
				if (pause) begin
					do @(posedge clk); while (pending_reports.size() != 0);
				end
				repeat (gap) @(posedge clk);
			end
			cmd_valid <= 1'b1;
			func <= req.func;
			load_year <= req.year;
			load_month <= req.month;
			load_day <= req.day;
			do @(posedge clk); while (cmd_stall);
			rep = step_date(req);
			if (idx < DIRECTED_ROWS && DIRECTED[idx].typed) begin
				rep = DIRECTED[idx].want;
			end
			pending_reports.push_back(rep);
		end
		cmd_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// result side
	initial begin
		day_report_t want;
		int unsigned hold;
		int unsigned seen;
		seen = 0;
		forever begin
			hold = (seen == HOLD_ITEM + 10) ? HOLD_CYCLES : idle_draw(seen);
			if (hold != 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				res_stall <= 1'b0;
			end
			do @(posedge clk); while (res_valid !== 1'b1);
			if (pending_reports.size() == 0) begin
				$error("result with no request pending: %0d-%0d-%0d", cur_year, cur_month,
					cur_day);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				check_field("cur_year", want.year, cur_year);
				check_field("cur_month", want.month, cur_month);
				check_field("cur_day", want.day, cur_day);
				check_field("month_length", want.mlen, month_length);
				check_field("first_weekday", want.wday, first_weekday);
				check_field("error_flag", want.err, error_flag);
			end
			seen++;
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
